>>> hdl/stb_pkg.sv
package stb_pkg;

  localparam int NUM_TIMERS = 16;
  localparam int IDX_W      = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;

  localparam logic [1:0] FUNC_START = 2'd0;
  localparam logic [1:0] FUNC_STOP  = 2'd1;
  localparam logic [1:0] FUNC_TICK  = 2'd2;

  localparam logic [1:0] KIND_STARTED = 2'd0;
  localparam logic [1:0] KIND_FAILED  = 2'd1;
  localparam logic [1:0] KIND_EXPIRED = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_CHECK,
    ST_FLUSH
  } state_t;

  typedef struct packed {
    logic [31:0] start_time;
    logic [15:0] length;
    logic [31:0] user_word;
  } slot_rec_t;

  typedef struct packed {
    logic             wr_en;
    logic             rd_en;
    logic [IDX_W-1:0] addr;
    slot_rec_t        wr_data;
  } ram_req_t;

endpackage

>>> hdl/stb_slot_ram.sv
module stb_slot_ram (
  input  logic                clk,
  input  stb_pkg::ram_req_t   req,
  output stb_pkg::slot_rec_t  rd_data
);

  stb_pkg::slot_rec_t mem [stb_pkg::NUM_TIMERS];

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_data <= mem[req.addr];
    end
  end

endmodule

>>> hdl/stb_ctrl.sv
module stb_ctrl (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [1:0]                   func,
  input  logic [15:0]                  duration,
  input  logic [3:0]                   timer_id,
  input  logic [31:0]                  tag,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [1:0]                   kind,
  output logic [3:0]                   slot_number,
  output logic [31:0]                  user_word,
  output logic                         last,
  output stb_pkg::ram_req_t            ram_req,
  input  stb_pkg::slot_rec_t           ram_rd
);

  stb_pkg::state_t                    state, state_next;
  logic [stb_pkg::IDX_W-1:0]          idx, idx_next;
  logic [stb_pkg::NUM_TIMERS-1:0]     busy, busy_next;
  logic [31:0]                        tick_count, tick_count_next;
  logic                               pend_valid, pend_valid_next;
  logic [stb_pkg::IDX_W-1:0]          pend_slot, pend_slot_next;
  logic [31:0]                        pend_word, pend_word_next;
  logic                               out_valid_next;
  logic [1:0]                         kind_next;
  logic [3:0]                         slot_number_next;
  logic [31:0]                        user_word_next;
  logic                               last_next;

  logic                               accept;
  logic                               out_can;
  logic                               free_any;
  logic [stb_pkg::IDX_W-1:0]          free_slot;
  logic [31:0]                        elapsed;
  logic                               hit;

  always_comb begin
    free_any  = 1'b0;
    free_slot = '0;
    for (int i = stb_pkg::NUM_TIMERS - 1; i >= 0; i--) begin
      if (!busy[i]) begin
        free_any  = 1'b1;
        free_slot = stb_pkg::IDX_W'(i);
      end
    end
  end

  assign elapsed = tick_count - ram_rd.start_time;
  assign hit     = busy[idx] && (elapsed >= {16'd0, ram_rd.length});
  assign out_can = !out_valid || !out_stall;

  always_comb begin
    state_next       = state;
    idx_next         = idx;
    busy_next        = busy;
    tick_count_next  = tick_count;
    pend_valid_next  = pend_valid;
    pend_slot_next   = pend_slot;
    pend_word_next   = pend_word;
    out_valid_next   = out_valid && out_stall;
    kind_next        = kind;
    slot_number_next = slot_number;
    user_word_next   = user_word;
    last_next        = last;
    ram_req          = '0;
    in_stall         = (state != stb_pkg::ST_IDLE) || (out_valid && out_stall);
    accept           = in_valid && !in_stall;

    unique case (state)
      stb_pkg::ST_IDLE: begin
        if (accept) begin
          unique case (func)
            stb_pkg::FUNC_START: begin
              out_valid_next = 1'b1;
              last_next      = 1'b1;
              user_word_next = '0;
              if (free_any) begin
                busy_next[free_slot]       = 1'b1;
                ram_req.wr_en              = 1'b1;
                ram_req.addr               = free_slot;
                ram_req.wr_data.start_time = tick_count;
                ram_req.wr_data.length     = duration;
                ram_req.wr_data.user_word  = tag;
                kind_next                  = stb_pkg::KIND_STARTED;
                slot_number_next           = 4'(free_slot);
              end else begin
                kind_next        = stb_pkg::KIND_FAILED;
                slot_number_next = '0;
              end
            end
            stb_pkg::FUNC_STOP: begin
              if ({1'b0, timer_id} < 5'(stb_pkg::NUM_TIMERS)) begin
                busy_next[stb_pkg::IDX_W'(timer_id)] = 1'b0;
              end
            end
            stb_pkg::FUNC_TICK: begin
              tick_count_next = tick_count + 32'd1;
              idx_next        = '0;
              pend_valid_next = 1'b0;
              state_next      = stb_pkg::ST_READ;
            end
            default: begin
            end
          endcase
        end
      end
      stb_pkg::ST_READ: begin
        ram_req.rd_en = 1'b1;
        ram_req.addr  = idx;
        state_next    = stb_pkg::ST_CHECK;
      end
      stb_pkg::ST_CHECK: begin
        if (!(hit && pend_valid && !out_can)) begin
          if (hit) begin
            if (pend_valid) begin
              out_valid_next   = 1'b1;
              kind_next        = stb_pkg::KIND_EXPIRED;
              slot_number_next = 4'(pend_slot);
              user_word_next   = pend_word;
              last_next        = 1'b0;
            end
            busy_next[idx]  = 1'b0;
            pend_valid_next = 1'b1;
            pend_slot_next  = idx;
            pend_word_next  = ram_rd.user_word;
          end
          if (idx == stb_pkg::IDX_W'(stb_pkg::NUM_TIMERS - 1)) begin
            state_next = stb_pkg::ST_FLUSH;
          end else begin
            idx_next   = idx + 1'b1;
            state_next = stb_pkg::ST_READ;
          end
        end
      end
      stb_pkg::ST_FLUSH: begin
        if (!pend_valid) begin
          state_next = stb_pkg::ST_IDLE;
        end else if (out_can) begin
          out_valid_next   = 1'b1;
          kind_next        = stb_pkg::KIND_EXPIRED;
          slot_number_next = 4'(pend_slot);
          user_word_next   = pend_word;
          last_next        = 1'b1;
          pend_valid_next  = 1'b0;
          state_next       = stb_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = stb_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= stb_pkg::ST_IDLE;
      idx        <= '0;
      busy       <= '0;
      tick_count <= '0;
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      idx        <= idx_next;
      busy       <= busy_next;
      tick_count <= tick_count_next;
      pend_valid <= pend_valid_next;
      out_valid  <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    pend_slot   <= pend_slot_next;
    pend_word   <= pend_word_next;
    kind        <= kind_next;
    slot_number <= slot_number_next;
    user_word   <= user_word_next;
    last        <= last_next;
  end

endmodule

>>> hdl/software_timer_bank_unit.sv
// Channel   Direction  Handshake            Payload
// input     in         in_valid / in_stall  func, duration, timer_id, tag
// result    out        out_valid / out_stall kind, slot_number, user_word, last
//
// A start or a stop is done on acceptance; a start result appears in the next cycle.
// A tick scans all sixteen slots, each slot passing a read state and a check
// state on the slot memory read port, and the scan ends in a flush state.
// Reset clears the busy flags, the tick count and the handshake state.
// A stalled result holds the scan; a new item is taken only once the scan ends
// and the result register is free or being taken.
module software_timer_bank_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  func,
  input  logic [15:0] duration,
  input  logic [3:0]  timer_id,
  input  logic [31:0] tag,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  kind,
  output logic [3:0]  slot_number,
  output logic [31:0] user_word,
  output logic        last
);

  stb_pkg::ram_req_t  ram_req;
  stb_pkg::slot_rec_t ram_rd;

  stb_slot_ram u_ram (
    .clk     (clk),
    .req     (ram_req),
    .rd_data (ram_rd)
  );

  stb_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .func        (func),
    .duration    (duration),
    .timer_id    (timer_id),
    .tag         (tag),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .kind        (kind),
    .slot_number (slot_number),
    .user_word   (user_word),
    .last        (last),
    .ram_req     (ram_req),
    .ram_rd      (ram_rd)
  );

endmodule

>>> hdl/stb_checker.sv
module stb_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_stall,
  input logic [1:0]  kind,
  input logic [3:0]  slot_number,
  input logic [31:0] user_word,
  input logic        last
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(kind) && $stable(slot_number)
      && $stable(user_word) && $stable(last))
    else $error("stalled result changed");

  a_kind: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> kind == stb_pkg::KIND_STARTED || kind == stb_pkg::KIND_FAILED
      || kind == stb_pkg::KIND_EXPIRED)
    else $error("result kind out of range");

  a_start_single: assert property (@(posedge clk) disable iff (rst)
    out_valid && (kind == stb_pkg::KIND_STARTED || kind == stb_pkg::KIND_FAILED)
      |-> last && user_word == 32'd0)
    else $error("start result not single or carries a word");

  a_fail_slot: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind == stb_pkg::KIND_FAILED |-> slot_number == 4'd0)
    else $error("failed start names a slot");

endmodule

bind software_timer_bank_unit stb_checker u_stb_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .kind        (kind),
  .slot_number (slot_number),
  .user_word   (user_word),
  .last        (last)
);

>>> tb/testbench.sv
`timescale 1ns / 100ps

module testbench;

  localparam logic [1:0] FUNC_NONE = 2'd3;
  localparam int CYCLE_LIMIT = 500000;
  localparam int RANDOM_ITEMS = 400;

  typedef struct packed {
    logic [1:0]  kind;
    logic [3:0]  slot;
    logic [31:0] word;
    logic        last;
  } timer_event_t;

  class expiry_scoreboard;
    bit             busy [stb_pkg::NUM_TIMERS];
    logic [31:0]    armed_at [stb_pkg::NUM_TIMERS];
    logic [15:0]    span [stb_pkg::NUM_TIMERS];
    logic [31:0]    word_of [stb_pkg::NUM_TIMERS];
    logic [31:0]    now_tick;
    timer_event_t   awaited [$];
    int             errors;

    function new();
      now_tick = '0;
      errors = 0;
      foreach (busy[i]) busy[i] = 1'b0;
    endfunction

    function int pending();
      return awaited.size();
    endfunction

    // Returns 1 when the item changes the state or yields a result.
    function bit note_request(logic [1:0] f, logic [15:0] d, logic [3:0] id,
                              logic [31:0] t);
      timer_event_t hits [$];
      timer_event_t ev;
      int free_slot;
      free_slot = -1;
      case (f)
        stb_pkg::FUNC_START: begin
          for (int i = stb_pkg::NUM_TIMERS - 1; i >= 0; i--) begin
            if (!busy[i]) free_slot = i;
          end
          if (free_slot < 0) begin
            awaited.push_back(timer_event_t'{stb_pkg::KIND_FAILED, 4'd0, 32'd0, 1'b1});
          end else begin
            busy[free_slot] = 1'b1;
            armed_at[free_slot] = now_tick;
            span[free_slot] = d;
            word_of[free_slot] = t;
            awaited.push_back(timer_event_t'{stb_pkg::KIND_STARTED, 4'(free_slot),
                                             32'd0, 1'b1});
          end
          return 1'b1;
        end
        stb_pkg::FUNC_STOP: begin
          if (id < stb_pkg::NUM_TIMERS && busy[id]) begin
            busy[id] = 1'b0;
            return 1'b1;
          end
          return 1'b0;
        end
        stb_pkg::FUNC_TICK: begin
          now_tick = now_tick + 32'd1;
          for (int i = 0; i < stb_pkg::NUM_TIMERS; i++) begin
            if (busy[i] && (now_tick - armed_at[i]) >= 32'(span[i])) begin
              busy[i] = 1'b0;
              hits.push_back(timer_event_t'{stb_pkg::KIND_EXPIRED, 4'(i), word_of[i],
                                            1'b0});
            end
          end
          foreach (hits[k]) begin
            ev = hits[k];
            ev.last = (k == hits.size() - 1);
            awaited.push_back(ev);
          end
          return 1'b1;
        end
        default: return 1'b0;
      endcase
    endfunction

    function void check_result(timer_event_t got);
      timer_event_t want;
      if (awaited.size() == 0) begin
        errors++;
        $display("%0t: result with none expected: kind %0d slot %0d word %h last %0d",
                 $time, got.kind, got.slot, got.word, got.last);
        return;
      end
      want = awaited.pop_front();
      if (got.kind !== want.kind) begin
        errors++;
        $display("%0t: kind expected %0d actual %0d", $time, want.kind, got.kind);
      end
      if (got.slot !== want.slot) begin
        errors++;
        $display("%0t: slot_number expected %0d actual %0d", $time, want.slot, got.slot);
      end
      if (got.word !== want.word) begin
        errors++;
        $display("%0t: user_word expected %h actual %h", $time, want.word, got.word);
      end
      if (got.last !== want.last) begin
        errors++;
        $display("%0t: last expected %0d actual %0d", $time, want.last, got.last);
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  func = FUNC_NONE;
  logic [15:0] duration = '0;
  logic [3:0]  timer_id = '0;
  logic [31:0] tag = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  kind;
  logic [3:0]  slot_number;
  logic [31:0] user_word;
  logic        last;

  expiry_scoreboard board;
  bit steady = 1'b0;
  int useful_items = 0;
  int cycle_count = 0;

  software_timer_bank_unit i_dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .func        (func),
    .duration    (duration),
    .timer_id    (timer_id),
    .tag         (tag),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .kind        (kind),
    .slot_number (slot_number),
    .user_word   (user_word),
    .last        (last)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("software_timer_bank_unit regression: fail");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_stall <= steady ? 1'b0 : ($urandom_range(0, 99) < 30);
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      board.check_result(timer_event_t'{kind, slot_number, user_word, last});
    end
  end

  task automatic issue_request(input logic [1:0] f, input logic [15:0] d,
                               input logic [3:0] id, input logic [31:0] t);
    if (!steady) begin
      while ($urandom_range(0, 99) < 30) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid <= 1'b1;
    func <= f;
    duration <= d;
    timer_id <= id;
    tag <= t;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (board.note_request(f, d, id, t)) useful_items++;
  endtask

  task automatic drain_pause();
    in_valid <= 1'b0;
    @(posedge clk);
    while (board.pending() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  function automatic logic [15:0] pick_span();
    int r;
    r = $urandom_range(0, 99);
    if (r < 85) return 16'($urandom_range(0, 6));
    if (r < 95) return 16'($urandom_range(0, 40));
    return 16'($urandom);
  endfunction

  task automatic random_request();
    int r;
    r = $urandom_range(0, 99);
    if (r < 3) begin
      repeat (stb_pkg::NUM_TIMERS + 1) begin
        issue_request(stb_pkg::FUNC_START, pick_span(), 4'($urandom), $urandom);
      end
    end else if (r < 40) begin
      issue_request(stb_pkg::FUNC_START, pick_span(), 4'($urandom), $urandom);
    end else if (r < 55) begin
      issue_request(stb_pkg::FUNC_STOP, 16'($urandom), 4'($urandom), $urandom);
    end else if (r < 95) begin
      issue_request(stb_pkg::FUNC_TICK, 16'($urandom), 4'($urandom), $urandom);
    end else begin
      issue_request(FUNC_NONE, 16'($urandom), 4'($urandom), $urandom);
    end
  endtask

  initial begin
    bit paused_once;
    paused_once = 1'b0;
    board = new();
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    issue_request(stb_pkg::FUNC_TICK, 16'hFFFF, 4'hF, 32'hFFFF_FFFF);
    issue_request(stb_pkg::FUNC_STOP, 16'h0000, 4'hF, 32'h0000_0000);
    issue_request(FUNC_NONE, 16'hFFFF, 4'hF, 32'hFFFF_FFFF);
    issue_request(stb_pkg::FUNC_START, 16'h0000, 4'h0, 32'hFFFF_FFFF);
    issue_request(stb_pkg::FUNC_START, 16'hFFFF, 4'hF, 32'h0000_0000);
    issue_request(stb_pkg::FUNC_TICK, 16'h0000, 4'h0, 32'h0000_0000);
    issue_request(stb_pkg::FUNC_STOP, 16'h0000, 4'h1, 32'h0000_0000);
    issue_request(stb_pkg::FUNC_STOP, 16'hFFFF, 4'h0, 32'hFFFF_FFFF);
    for (int i = 0; i < stb_pkg::NUM_TIMERS; i++) begin
      issue_request(stb_pkg::FUNC_START, 16'(i % 3), 4'($urandom), $urandom);
    end
    issue_request(stb_pkg::FUNC_START, 16'h0001, 4'h0, 32'h1234_5678);

    drain_pause();
    useful_items = 0;
    while (useful_items < RANDOM_ITEMS) begin
      steady = (useful_items >= 150 && useful_items < 230);
      if (!paused_once && useful_items >= 300) begin
        paused_once = 1'b1;
        drain_pause();
      end
      random_request();
    end
    steady = 1'b0;
    in_valid <= 1'b0;

    while (board.pending() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (board.errors == 0 && board.pending() == 0) begin
      $display("software_timer_bank_unit regression: pass");
    end else begin
      $display("software_timer_bank_unit regression: fail");
    end
    $finish;
  end

endmodule
